>>> hdl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the serial radio frame decoder: input
// operation codes, register map, reset values and controller interface types.
// ----------------------------------------------------------------------------
package rcd_pkg;

	// Default geometry of a frame.
	localparam int FRAME_BYTES_DEF  = 16;
	localparam int NUM_CHANNELS_DEF = 8;

	// Configuration port.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_GAP_TICKS    = 2'd0;
	localparam logic [1:0] REG_VALID_WINDOW = 2'd1;
	localparam logic [1:0] REG_BIND_HALF    = 2'd2;
	localparam logic [1:0] REG_BIND_PULSES  = 2'd3;

	localparam logic [15:0] GAP_TICKS_RST    = 16'd1000;
	localparam logic [19:0] VALID_WINDOW_RST = 20'd100000;
	localparam logic [15:0] BIND_HALF_RST    = 16'd119;
	localparam logic [3:0]  BIND_PULSES_RST  = 4'd6;

	// Input operation codes.
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_BIND = 2'd2;

	// Result kinds.
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_CHANNEL = 1'b1;

	// Value reported for a channel that was not received (-1).
	localparam logic [10:0] CH_NOT_RECEIVED = 11'h7FF;

	localparam logic [19:0] SINCE_MAX = 20'hFFFFF;

	typedef struct packed {
		logic [15:0] gap_ticks;
		logic [19:0] valid_window_ticks;
		logic [15:0] bind_half_ticks;
		logic [3:0]  bind_pulses;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic apply;        // apply the accepted input item to the state
		logic frame_end;    // the accepted tick closes a frame
		logic rd_en;        // read one byte of the frame store
		logic load_status;  // load a status result into the output register
		logic load_chan;    // load a channel result into the output register
		logic out_last;     // final result of the current item
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic gap_expire;   // a tick now would end the frame
		logic frame_full;   // exactly a full frame has been stored
	} stat_t;

endpackage

>>> hdl/rcd_regs.sv
// ----------------------------------------------------------------------------
// rcd_regs
// Configuration register bank behind an APB-style port; word aligned
// registers, writes complete in the access phase, zero wait states.
// ----------------------------------------------------------------------------
module rcd_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rcd_pkg::ADDR_W-1:0] paddr,
	input  logic [rcd_pkg::DATA_W-1:0] pwdata,
	output logic [rcd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rcd_pkg::cfg_t              cfg
);
	import rcd_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks          <= GAP_TICKS_RST;
			cfg_q.valid_window_ticks <= VALID_WINDOW_RST;
			cfg_q.bind_half_ticks    <= BIND_HALF_RST;
			cfg_q.bind_pulses        <= BIND_PULSES_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_GAP_TICKS:    cfg_q.gap_ticks          <= pwdata[15:0];
				REG_VALID_WINDOW: cfg_q.valid_window_ticks <= pwdata[19:0];
				REG_BIND_HALF:    cfg_q.bind_half_ticks    <= pwdata[15:0];
				REG_BIND_PULSES:  cfg_q.bind_pulses        <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GAP_TICKS:    prdata = {16'd0, cfg_q.gap_ticks};
			REG_VALID_WINDOW: prdata = {12'd0, cfg_q.valid_window_ticks};
			REG_BIND_HALF:    prdata = {16'd0, cfg_q.bind_half_ticks};
			REG_BIND_PULSES:  prdata = {28'd0, cfg_q.bind_pulses};
			default:          prdata = '0;
		endcase
	end

endmodule

>>> hdl/rcd_ctrl.sv
// ----------------------------------------------------------------------------
// rcd_ctrl
// Controller: input acceptance, frame store read sequence during decode,
// result emission and the valid flag of the output register.
// ----------------------------------------------------------------------------
module rcd_ctrl #(
	parameter  int FRAME_BYTES  = rcd_pkg::FRAME_BYTES_DEF,
	parameter  int NUM_CHANNELS = rcd_pkg::NUM_CHANNELS_DEF,
	localparam int AW           = $clog2(FRAME_BYTES),
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       op,
	output logic             out_valid,
	input  logic             out_stall,
	input  rcd_pkg::stat_t   st,
	output rcd_pkg::cmd_t    cmd,
	output logic [AW-1:0]    rd_addr,
	output logic [CH_W-1:0]  emit_idx
);
	import rcd_pkg::*;

	localparam int LAST_ADDR_I = 2 * ((FRAME_BYTES - 2) / 2) + 1;
	localparam logic [AW-1:0]   FIRST_ADDR = AW'(2);
	localparam logic [AW-1:0]   LAST_ADDR  = AW'(LAST_ADDR_I);
	localparam logic [CH_W-1:0] LAST_CH    = CH_W'(NUM_CHANNELS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_STATUS = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]      state_q, state_d;
	logic [AW-1:0]   rd_addr_q;
	logic [CH_W-1:0] emit_idx_q;
	logic            out_valid_q;
	logic            out_free;
	logic            emit_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = (emit_idx_q == LAST_CH);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign rd_addr   = rd_addr_q;
	assign emit_idx  = emit_idx_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.apply = 1'b1;
					if (op == OP_TICK && st.gap_expire) begin
						cmd.frame_end = 1'b1;
						state_d = st.frame_full ? ST_READ : ST_EMIT;
					end else begin
						state_d = ST_STATUS;
					end
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					cmd.load_status = 1'b1;
					cmd.out_last    = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				if (rd_addr_q == LAST_ADDR) begin
					state_d = ST_DRAIN;
				end
			end
			// The last byte read is still being folded into the channel table.
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_chan = 1'b1;
					cmd.out_last  = emit_last;
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_addr_q   <= FIRST_ADDR;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.frame_end) begin
				rd_addr_q <= FIRST_ADDR;
			end else if (cmd.rd_en) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			if (cmd.load_chan) begin
				emit_idx_q <= emit_last ? '0 : emit_idx_q + CH_W'(1);
			end
			if (cmd.load_status || cmd.load_chan) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/rcd_dp.sv
// ----------------------------------------------------------------------------
// rcd_dp
// Datapath: frame store, gap timer, link watchdog, bind pulser, channel
// table filled word by word during decode, and the output register.
// ----------------------------------------------------------------------------
module rcd_dp #(
	parameter  int FRAME_BYTES  = rcd_pkg::FRAME_BYTES_DEF,
	parameter  int NUM_CHANNELS = rcd_pkg::NUM_CHANNELS_DEF,
	localparam int AW           = $clog2(FRAME_BYTES),
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rcd_pkg::cfg_t      cfg,
	input  logic [1:0]         op,
	input  logic [7:0]         data_byte,
	input  rcd_pkg::cmd_t      cmd,
	input  logic [AW-1:0]      rd_addr,
	input  logic [CH_W-1:0]    emit_idx,
	output rcd_pkg::stat_t     st,
	output logic               kind,
	output logic [CH_W-1:0]    channel_index,
	output logic signed [10:0] channel_value,
	output logic               frame_good,
	output logic [7:0]         header_byte,
	output logic               link_valid,
	output logic               bind_pin,
	output logic               last
);
	import rcd_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(FRAME_BYTES);

	// Frame store and decode pipeline.
	logic [7:0]      frame_mem [FRAME_BYTES];
	logic [7:0]      rd_data_s1;
	logic            rd_valid_s1;
	logic            rd_odd_s1;
	logic [7:0]      hi_byte_q;
	logic [10:0]     chan_q [NUM_CHANNELS];

	// Receiver and timer state.
	logic [CW-1:0]   byte_count_q;
	logic [7:0]      pend_header_q;
	logic [7:0]      kept_header_q;
	logic            frame_good_q;
	logic [15:0]     gap_count_q;
	logic            gap_running_q;
	logic [19:0]     since_good_q;
	logic [3:0]      bind_left_q;
	logic [15:0]     bind_phase_q;
	logic            bind_level_q;

	// Output register.
	logic            out_kind_q;
	logic [CH_W-1:0] out_idx_q;
	logic [10:0]     out_value_q;
	logic            out_good_q;
	logic [7:0]      out_header_q;
	logic            out_link_q;
	logic            out_pin_q;
	logic            out_last_q;

	logic            full;
	logic            binding;
	logic            store_byte;
	logic [16:0]     gap_sum;
	logic [16:0]     phase_sum;
	logic            phase_wrap;
	logic [15:0]     word;
	logic [5:0]      word_ch;

	assign full       = (byte_count_q == FULL_COUNT);
	assign binding    = (bind_left_q != 4'd0);
	assign gap_sum    = {1'b0, gap_count_q} + 17'd1;
	assign phase_sum  = {1'b0, bind_phase_q} + 17'd1;
	assign phase_wrap = (phase_sum >= {1'b0, cfg.bind_half_ticks});
	assign store_byte = cmd.apply && op == OP_BYTE && !binding && !full;
	assign word       = {hi_byte_q, rd_data_s1};
	assign word_ch    = word[15:10];

	assign st.gap_expire = !binding && gap_running_q && (gap_sum >= {1'b0, cfg.gap_ticks});
	assign st.frame_full = full;

	always_ff @(posedge clk) begin
		if (store_byte) begin
			frame_mem[byte_count_q[AW-1:0]] <= data_byte;
		end
		rd_data_s1 <= frame_mem[rd_addr];
	end

	// Word assembly: even addresses carry the high byte, odd the low byte.
	always_ff @(posedge clk) begin
		rd_odd_s1 <= rd_addr[0];
		if (rd_valid_s1 && !rd_odd_s1) begin
			hi_byte_q <= rd_data_s1;
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (cmd.frame_end) begin
				chan_q[c] <= CH_NOT_RECEIVED;
			end else if (rd_valid_s1 && rd_odd_s1 && word_ch == 6'(c)) begin
				chan_q[c] <= {1'b0, word[9:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1   <= 1'b0;
			byte_count_q  <= '0;
			pend_header_q <= '0;
			kept_header_q <= '0;
			frame_good_q  <= 1'b0;
			gap_count_q   <= '0;
			gap_running_q <= 1'b0;
			since_good_q  <= SINCE_MAX;
			bind_left_q   <= '0;
			bind_phase_q  <= '0;
			bind_level_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.apply) begin
				case (op)
					OP_BYTE: begin
						if (!binding) begin
							if (!full) begin
								byte_count_q <= byte_count_q + CW'(1);
							end
							if (byte_count_q == CW'(1)) begin
								pend_header_q <= data_byte;
							end
							gap_count_q   <= '0;
							gap_running_q <= 1'b1;
						end
					end
					OP_TICK: begin
						if (cmd.frame_end && full) begin
							since_good_q <= '0;
						end else if (since_good_q != SINCE_MAX) begin
							since_good_q <= since_good_q + 20'd1;
						end
						if (binding) begin
							if (phase_wrap) begin
								bind_phase_q <= '0;
								bind_level_q <= !bind_level_q;
								// Each fall back to low completes one pulse.
								if (bind_level_q) begin
									bind_left_q <= bind_left_q - 4'd1;
								end
							end else begin
								bind_phase_q <= phase_sum[15:0];
							end
						end else if (gap_running_q) begin
							if (cmd.frame_end) begin
								gap_running_q <= 1'b0;
								gap_count_q   <= '0;
								byte_count_q  <= '0;
								frame_good_q  <= full;
								if (full) begin
									kept_header_q <= pend_header_q;
								end
							end else begin
								gap_count_q <= gap_sum[15:0];
							end
						end
					end
					OP_BIND: begin
						bind_left_q   <= cfg.bind_pulses;
						bind_phase_q  <= '0;
						bind_level_q  <= 1'b0;
						gap_running_q <= 1'b0;
						gap_count_q   <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status || cmd.load_chan) begin
			out_header_q <= kept_header_q;
			out_link_q   <= (since_good_q < cfg.valid_window_ticks);
			out_pin_q    <= bind_level_q;
			out_last_q   <= cmd.out_last;
			if (cmd.load_chan) begin
				out_kind_q  <= KIND_CHANNEL;
				out_idx_q   <= emit_idx;
				out_value_q <= chan_q[emit_idx];
				out_good_q  <= frame_good_q;
			end else begin
				out_kind_q  <= KIND_STATUS;
				out_idx_q   <= '0;
				out_value_q <= '0;
				out_good_q  <= 1'b0;
			end
		end
	end

	assign kind          = out_kind_q;
	assign channel_index = out_idx_q;
	assign channel_value = out_value_q;
	assign frame_good    = out_good_q;
	assign header_byte   = out_header_q;
	assign link_valid    = out_link_q;
	assign bind_pin      = out_pin_q;
	assign last          = out_last_q;

endmodule

>>> hdl/rc_serial_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_top
// Serial radio receiver frame decoder with link watchdog and bind pulser.
// ----------------------------------------------------------------------------
// Input items are received bytes, time ticks and bind requests; one item is
// taken at a time. An item that does not end a frame yields one status result
// and occupies the block through its accept and the load of the output
// register. A tick whose gap timer expires ends the frame and yields
// NUM_CHANNELS channel results: for a full frame the single read port of the
// frame store delivers one byte a cycle to the word decoder for the bytes from
// address 2 up, before the results are emitted; a short frame goes straight
// to emission. An output register separates the result side, so a stalled
// output only holds the block once that register is full. Registers (byte
// addresses): 0x0 gap ticks, 0x4 valid window ticks, 0x8 bind half period
// ticks, 0xC bind pulses.
module rc_serial_frame_decoder_top #(
	parameter  int FRAME_BYTES  = rcd_pkg::FRAME_BYTES_DEF,
	parameter  int NUM_CHANNELS = rcd_pkg::NUM_CHANNELS_DEF,
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rcd_pkg::ADDR_W-1:0] paddr,
	input  logic [rcd_pkg::DATA_W-1:0] pwdata,
	output logic [rcd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       kind,
	output logic [CH_W-1:0]            channel_index,
	output logic signed [10:0]         channel_value,
	output logic                       frame_good,
	output logic [7:0]                 header_byte,
	output logic                       link_valid,
	output logic                       bind_pin,
	output logic                       last
);
	import rcd_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);

	cfg_t            cfg;
	cmd_t            cmd;
	stat_t           st;
	logic [AW-1:0]   rd_addr;
	logic [CH_W-1:0] emit_idx;

	rcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcd_ctrl #(
		.FRAME_BYTES  (FRAME_BYTES),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.emit_idx  (emit_idx)
	);

	rcd_dp #(
		.FRAME_BYTES  (FRAME_BYTES),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.op            (op),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.emit_idx      (emit_idx),
		.st            (st),
		.kind          (kind),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.frame_good    (frame_good),
		.header_byte   (header_byte),
		.link_valid    (link_valid),
		.bind_pin      (bind_pin),
		.last          (last)
	);

endmodule

>>> hdl/rcd_checker.sv
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rcd_checker #(
	parameter  int NUM_CHANNELS = rcd_pkg::NUM_CHANNELS_DEF,
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               kind,
	input logic [CH_W-1:0]    channel_index,
	input logic signed [10:0] channel_value,
	input logic               last
);
	import rcd_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its channel fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(channel_index) && $stable(channel_value))
		else $error("result changed while stalled");

	// Items are processed one at a time: the cycle after an accept is busy.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while one is in progress");

	// A status result is always the only result of its item.
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> last && channel_value == 11'sd0)
		else $error("malformed status result");

	// The channel sequence of a frame closes on the highest channel.
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CHANNEL && last |-> channel_index == CH_W'(NUM_CHANNELS - 1))
		else $error("frame results closed on the wrong channel");

endmodule

bind rc_serial_frame_decoder_top rcd_checker #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_rcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.channel_index (channel_index),
	.channel_value (channel_value),
	.last          (last)
);

>>> tb/sv/rc_serial_frame_decoder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_top_test
// Self-checking testbench for the serial radio frame decoder. Received bytes,
// time ticks and bind requests are driven over the input channel. A
// cycle-level prediction of the decoder state produces the expected status
// and channel results, and each result leaving the block is compared with the
// oldest expected one. Directed cases come first, then randomized frame
// traffic under several register settings with random idle cycles on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_top_test;
	import rcd_pkg::*;

	localparam int FRAME_LEN   = FRAME_BYTES_DEF;
	localparam int NUM_CH      = NUM_CHANNELS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 200;

	// The op field is two bits wide; its fourth code has no function.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [2:0]  chan;
		logic [10:0] value;
		logic        good;
		logic [7:0]  hdr;
		logic        link;
		logic        pin;
		logic        last;
	} decoder_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [2:0]  channel_index;
	logic signed [10:0] channel_value;
	logic        frame_good;
	logic [7:0]  header_byte;
	logic        link_valid;
	logic        bind_pin;
	logic        last;

	// Predicted decoder state and register copy.
	cfg_t        p_cfg;
	logic [7:0]  p_store [FRAME_LEN];
	int unsigned p_fill;
	logic [15:0] p_idle_ticks;
	logic        p_gap_armed;
	logic [7:0]  p_hdr;
	logic [19:0] p_link_age;
	logic [3:0]  p_pulses_left;
	logic [15:0] p_phase_ticks;
	logic        p_pin_level;

	decoder_result_t predicted_results [$];
	int unsigned items_applied = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int rx_wait = 0;
	int hold_req = 0;
	bit hold_active = 1'b0;

	rc_serial_frame_decoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.frame_good    (frame_good),
		.header_byte   (header_byte),
		.link_valid    (link_valid),
		.bind_pin      (bind_pin),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic void push_result(logic k, logic [2:0] idx, logic [10:0] val,
			logic good, logic lst);
		decoder_result_t r;
		r.kind  = k;
		r.chan  = idx;
		r.value = val;
		r.good  = good;
		r.hdr   = p_hdr;
		r.link  = (p_link_age < p_cfg.valid_window_ticks);
		r.pin   = p_pin_level;
		r.last  = lst;
		predicted_results.push_back(r);
	endfunction

	function automatic void close_frame();
		logic [10:0] vals [NUM_CH];
		logic [15:0] word;
		logic        good;
		good = (p_fill == FRAME_LEN);
		for (int c = 0; c < NUM_CH; c++)
			vals[c] = CH_NOT_RECEIVED;
		if (good) begin
			// Later words override earlier ones for the same channel.
			for (int i = 2; i + 1 < FRAME_LEN; i += 2) begin
				word = {p_store[i], p_store[i + 1]};
				if (word[15:10] < NUM_CH)
					vals[word[15:10]] = {1'b0, word[9:0]};
			end
			p_hdr      = p_store[1];
			p_link_age = '0;
		end
		p_fill = 0;
		for (int c = 0; c < NUM_CH; c++)
			push_result(KIND_CHANNEL, c[2:0], vals[c], good, c == NUM_CH - 1);
	endfunction

	function automatic void predict_decoder_step(logic [1:0] code, logic [7:0] value);
		if (!(code == OP_BYTE && p_pulses_left != 0))
			items_applied++;
		case (code)
			OP_BYTE: begin
				// The receive line is driven during bind, so bytes are ignored.
				if (p_pulses_left == 0) begin
					if (p_fill < FRAME_LEN) begin
						p_store[p_fill] = value;
						p_fill++;
					end
					p_idle_ticks = '0;
					p_gap_armed  = 1'b1;
				end
			end
			OP_TICK: begin
				if (p_link_age != SINCE_MAX)
					p_link_age++;
				if (p_pulses_left != 0) begin
					p_phase_ticks++;
					if (p_phase_ticks >= p_cfg.bind_half_ticks) begin
						p_phase_ticks = '0;
						p_pin_level   = ~p_pin_level;
						if (!p_pin_level)
							p_pulses_left--;
					end
				end else if (p_gap_armed) begin
					p_idle_ticks++;
					if (p_idle_ticks >= p_cfg.gap_ticks) begin
						p_gap_armed  = 1'b0;
						p_idle_ticks = '0;
						close_frame();
						return;
					end
				end
			end
			OP_BIND: begin
				p_pulses_left = p_cfg.bind_pulses;
				p_phase_ticks = '0;
				p_pin_level   = 1'b0;
				p_gap_armed   = 1'b0;
				p_idle_ticks  = '0;
			end
			default: ;
		endcase
		push_result(KIND_STATUS, '0, '0, 1'b0, 1'b1);
	endfunction

	// ------------------------------------------------------------------------
	// Result side: stall pattern, long hold-off and checking
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_active) begin
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		forever begin
			wait (hold_req > 0);
			hold_active = 1'b1;
			repeat (hold_req) @(posedge clk);
			hold_active = 1'b0;
			hold_req = 0;
		end
	end

	always @(posedge clk) begin : check_results
		decoder_result_t want;
		decoder_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			rx_wait = rx_idle_en ? int'($urandom_range(0, 3)) : 0;
			got = {kind, channel_index, channel_value, frame_good, header_byte,
				link_valid, bind_pin, last};
			if (predicted_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result kind=%0d ch=%0d val=%0d", $realtime,
						got.kind, got.chan, $signed(got.value));
			end else begin
				want = predicted_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: result mismatch\n",
							"  expected kind=%0d ch=%0d val=%0d good=%0d hdr=%02h link=%0d",
							" pin=%0d last=%0d\n",
							"  actual   kind=%0d ch=%0d val=%0d good=%0d hdr=%02h link=%0d",
							" pin=%0d last=%0d"}, $realtime,
							want.kind, want.chan, $signed(want.value), want.good, want.hdr,
							want.link, want.pin, want.last,
							got.kind, got.chan, $signed(got.value), got.good, got.hdr,
							got.link, got.pin, got.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side and register access (all called at a falling edge)
	// ------------------------------------------------------------------------
	task automatic send_item(logic [1:0] code, logic [7:0] value);
		int gap;
		gap = tx_idle_en ? int'($urandom_range(0, 3)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		op        <= code;
		data_byte <= value;
		do
			@(posedge clk);
		while (in_stall);
		predict_decoder_step(code, value);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_GAP_TICKS:    p_cfg.gap_ticks          = value[15:0];
			REG_VALID_WINDOW: p_cfg.valid_window_ticks = value[19:0];
			REG_BIND_HALF:    p_cfg.bind_half_ticks    = value[15:0];
			REG_BIND_PULSES:  p_cfg.bind_pulses        = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(int unsigned gap, int unsigned window, int unsigned half,
			int unsigned pulses);
		write_reg(REG_GAP_TICKS, gap);
		write_reg(REG_VALID_WINDOW, window);
		write_reg(REG_BIND_HALF, half);
		write_reg(REG_BIND_PULSES, pulses);
	endtask

	// Enough ticks to expire the idle gap of the current setting.
	task automatic send_gap_ticks();
		int unsigned n;
		n = (p_cfg.gap_ticks == 0) ? 1 : p_cfg.gap_ticks;
		repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		logic [5:0]  chan;
		logic [9:0]  level;
		send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		repeat (7) begin
			// Mostly valid channels, now and then one that must be ignored.
			chan  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(8, 63))
				: 6'($urandom_range(0, NUM_CH - 1));
			level = 10'($urandom_range(0, 1023));
			send_item(OP_BYTE, {chan, level[9:8]});
			send_item(OP_BYTE, level[7:0]);
		end
		send_gap_ticks();
	endtask

	task automatic send_bind_train();
		int unsigned n;
		send_item(OP_BIND, 8'($urandom_range(0, 255)));
		n = 2 * p_cfg.bind_pulses * ((p_cfg.bind_half_ticks == 0) ? 1 : p_cfg.bind_half_ticks);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				send_item(OP_BYTE, 8'($urandom_range(0, 255)));
			send_item(OP_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_noise();
		int unsigned n;
		int unsigned pick;
		logic [1:0]  code;
		n = $urandom_range(1, 6);
		repeat (n) begin
			pick = $urandom_range(0, 7);
			if (pick <= 2)
				code = OP_BYTE;
			else if (pick <= 5)
				code = OP_TICK;
			else if (pick == 6)
				code = OP_BIND;
			else
				code = OP_UNKNOWN;
			send_item(code, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random_phase(int unsigned target);
		int unsigned first;
		int unsigned pick;
		int unsigned n;
		first = items_applied;
		while (items_applied - first < target) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				send_random_frame();
			end else if (pick == 6) begin
				// Short, full or overlong frame.
				n = $urandom_range(1, FRAME_LEN + 4);
				repeat (n) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
				send_gap_ticks();
			end else if (pick == 7) begin
				send_bind_train();
			end else begin
				send_noise();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_reset_state();
		// Link starts invalid and the age counter stays saturated on a tick.
		send_item(OP_UNKNOWN, 8'hFF);
		send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_full_frame();
		logic [7:0] frame [17] = '{8'hFF, 8'hA5,
			8'h00, 8'h00,   // channel 0, lowest value
			8'h1F, 8'hFF,   // channel 7, highest value
			8'hFF, 8'hFF,   // channel 63, ignored
			8'h09, 8'h55,   // channel 2
			8'h0A, 8'hAA,   // channel 2 again, this one wins
			8'h20, 8'h00,   // channel 8, ignored
			8'h17, 8'hFF,   // channel 5
			8'h42};         // seventeenth byte is dropped
		set_config(2, 32'h000F_FFFF, 32'(BIND_HALF_RST), 32'(BIND_PULSES_RST));
		foreach (frame[i])
			send_item(OP_BYTE, frame[i]);
		send_gap_ticks();
	endtask

	task automatic test_short_frame_zero_gap();
		// With a gap of zero the first tick after a byte ends the frame.
		set_config(0, 1, 32'(BIND_HALF_RST), 32'(BIND_PULSES_RST));
		send_item(OP_BYTE, 8'h81);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_bind_pulser();
		// Upper bits of the written value must be masked off.
		write_reg(REG_BIND_PULSES, 32'hFFFF_FFF1);
		write_reg(REG_BIND_HALF, 32'h0000_0000);
		send_item(OP_BIND, 8'h00);
		send_item(OP_BYTE, 8'h5A);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h3C);
		send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_extreme_settings();
		set_config(32'h0000_FFFF, 32'h000F_FFFF, 32'h0000_FFFF, 15);
		repeat (12) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		repeat (6) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		send_item(OP_BIND, 8'h00);
		repeat (3) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
		repeat (4) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		// A bind request with zero pulses ends the running pulse train.
		write_reg(REG_BIND_PULSES, 32'hFFFF_FFF0);
		send_item(OP_BIND, 8'h00);
		repeat (2) send_item(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			tx_idle_en = (phase == 0 || phase == 2);
			rx_idle_en = (phase == 0 || phase == 3);
			set_config($urandom_range(0, 4), $urandom_range(1, 40), $urandom_range(0, 3),
				$urandom_range(1, 4));
			run_random_phase(25);
		end
	endtask

	task automatic test_output_backpressure();
		// The receiver holds off long enough for the block to stall its input
		// while the sender keeps offering transactions.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		set_config(1, 60, 1, 2);
		hold_req = HOLD_CYCLES;
		repeat (3) send_random_frame();
		rx_idle_en = 1'b1;
		tx_idle_en = 1'b1;
		send_random_frame();
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		op        = OP_BYTE;
		data_byte = '0;

		p_cfg.gap_ticks          = GAP_TICKS_RST;
		p_cfg.valid_window_ticks = VALID_WINDOW_RST;
		p_cfg.bind_half_ticks    = BIND_HALF_RST;
		p_cfg.bind_pulses        = BIND_PULSES_RST;
		p_fill        = 0;
		p_idle_ticks  = '0;
		p_gap_armed   = 1'b0;
		p_hdr         = '0;
		p_link_age    = SINCE_MAX;
		p_pulses_left = '0;
		p_phase_ticks = '0;
		p_pin_level   = 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_full_frame();
		test_short_frame_zero_gap();
		test_bind_pulser();
		test_extreme_settings();
		test_random_traffic();
		test_output_backpressure();

		in_valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
